// ===== rtl/core/dns_query_question_parser_defines.svh =====
// Assertion macros used by the checker file.
`ifndef DNS_QUERY_QUESTION_PARSER_DEFINES_SVH
`define DNS_QUERY_QUESTION_PARSER_DEFINES_SVH

// Checked only while reset is released.
`define DQQP_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("dqqp assertion failed");

// Checked on every rising clock edge, reset included.
`define DQQP_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("dqqp assertion failed");

`endif

// ===== rtl/core/dqqp_pkg.sv =====
package dqqp_pkg;

  localparam int          NAME_LIMIT   = 256;
  localparam logic [15:0] WANTED_RESET = 16'd28;
  localparam int          HDR_BYTES    = 12;
  localparam logic [3:0]  HDR_LAST     = 4'(HDR_BYTES - 1);
  localparam logic [7:0]  DOT_CHAR     = 8'h2E;
  localparam int          QUEUE_DEPTH  = 4;

  typedef enum logic [2:0] {
    PH_HEADER    = 3'd0,
    PH_LENGTH    = 3'd1,
    PH_LABEL     = 3'd2,
    PH_TYPECLASS = 3'd3,
    PH_IGNORE    = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_QDONE   = 2'd1,
    KIND_VERDICT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    V_FOUND     = 3'd0,
    V_SHORT_HDR = 3'd1,
    V_NON_QUEST = 3'd2,
    V_NAME_LONG = 3'd3,
    V_TRUNCATED = 3'd4,
    V_NO_MATCH  = 3'd5
  } verdict_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  name_char;
    logic [15:0] question_index;
    logic [15:0] query_type;
    logic [15:0] query_class;
    logic [15:0] message_id;
    verdict_e    verdict;
    logic        final_of_packet;
  } result_t;

  function automatic result_t mk_char(logic [7:0] ch, logic [15:0] qidx, logic [15:0] id);
    result_t r;
    r = '0;
    r.kind           = KIND_CHAR;
    r.name_char      = ch;
    r.question_index = qidx;
    r.message_id     = id;
    r.verdict        = V_FOUND;
    return r;
  endfunction

  function automatic result_t mk_qdone(logic [15:0] qidx, logic [15:0] qt, logic [15:0] qc,
                                       logic [15:0] id);
    result_t r;
    r = '0;
    r.kind           = KIND_QDONE;
    r.question_index = qidx;
    r.query_type     = qt;
    r.query_class    = qc;
    r.message_id     = id;
    r.verdict        = V_FOUND;
    return r;
  endfunction

  function automatic result_t mk_verdict(verdict_e v, logic [15:0] qidx, logic [15:0] qt,
                                         logic [15:0] qc, logic [15:0] id);
    result_t r;
    r = '0;
    r.kind            = KIND_VERDICT;
    r.question_index  = qidx;
    r.query_type      = qt;
    r.query_class     = qc;
    r.message_id      = id;
    r.verdict         = v;
    r.final_of_packet = 1'b1;
    return r;
  endfunction

endpackage

// ===== rtl/core/dns_query_question_parser.sv =====
// DNS query question parser. Bytes of one query message enter on the slave
// stream, one per cycle, with tlast on the final byte. Each byte is handled in
// the cycle it is accepted and its results (name characters, a finished
// question with its type and class, and one final verdict per packet) go into
// a four-item result queue that drives the master stream; a byte may yield up
// to two results. A new byte is taken in every cycle while the queue has room
// for two results, so the rate is one byte per cycle and drops only while the
// consumer stalls or while two-result bytes outpace the one result per cycle
// that the master side delivers. The wanted question type resets to 28 (AAAA). The
// user writes it via cfg_we_i/cfg_wdata_i only while the block is idle; not enforced.
module dns_query_question_parser import dqqp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [7:0] name_char, [23:8] question_index,
                                      // [39:24] query_type, [55:40] query_class,
                                      // [71:56] message_id, [74:72] verdict, rest zero
  output logic        m_axis_tlast,   // final_of_packet
  output logic [1:0]  m_axis_tuser    // result_kind
);

  logic [15:0] wanted_q;
  phase_e      phase_q, phase_d;
  logic [3:0]  hpos_q;
  logic [15:0] held_id_q;
  logic [15:0] qtotal_q;
  logic        other_q;
  logic [15:0] qnum_q;
  logic [7:0]  lbl_rem_q;
  logic [8:0]  name_len_q;
  logic [1:0]  tc_pos_q;
  logic [31:0] tc_word_q;

  logic        accept;
  logic [7:0]  b;
  logic        last;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign b      = s_axis_tdata;
  assign last   = s_axis_tlast;

  // Shared decode of the current byte.
  logic [15:0] id_n;
  logic        other_n;
  logic [8:0]  len_pos;
  logic [9:0]  len_sum;
  logic        too_long;
  logic [31:0] tc_word_n;
  logic [15:0] qtype;
  logic [15:0] qclass;
  logic [15:0] qnum_inc;
  logic        type_hit;

  assign id_n      = (phase_q == PH_HEADER && hpos_q < 4'd2) ? {held_id_q[7:0], b} : held_id_q;
  assign other_n   = other_q || (hpos_q >= 4'd6 && b != 8'd0);
  assign len_pos   = name_len_q + ((name_len_q != 9'd0) ? 9'd1 : 9'd0);
  assign len_sum   = {1'b0, len_pos} + {2'b00, b};
  assign too_long  = len_sum >= 10'(NAME_LIMIT);
  assign tc_word_n = {tc_word_q[23:0], b};
  assign qtype     = tc_word_n[31:16];
  assign qclass    = tc_word_n[15:0];
  assign qnum_inc  = qnum_q + 16'd1;
  assign type_hit  = qtype == wanted_q;

  // Results of the current byte.
  result_t     res0, res1;
  logic [1:0]  n_res;
  logic        fin;

  always_comb begin
    res0  = '0;
    res1  = '0;
    n_res = 2'd0;
    unique case (phase_q)
      PH_HEADER: begin
        if (hpos_q < HDR_LAST) begin
          if (last) begin
            res0  = mk_verdict(V_SHORT_HDR, qnum_q, 16'd0, 16'd0, id_n);
            n_res = 2'd1;
          end
        end else if (other_n) begin
          // Other records win over a zero question count.
          res0  = mk_verdict(V_NON_QUEST, qnum_q, 16'd0, 16'd0, id_n);
          n_res = 2'd1;
        end else if (qtotal_q == 16'd0) begin
          res0  = mk_verdict(V_NO_MATCH, qnum_q, 16'd0, 16'd0, id_n);
          n_res = 2'd1;
        end else if (last) begin
          res0  = mk_verdict(V_TRUNCATED, qnum_q, 16'd0, 16'd0, id_n);
          n_res = 2'd1;
        end
      end
      PH_LENGTH: begin
        if (b == 8'd0) begin
          if (last) begin
            res0  = mk_verdict(V_TRUNCATED, qnum_q, 16'd0, 16'd0, id_n);
            n_res = 2'd1;
          end
        end else if (too_long) begin
          res0  = mk_verdict(V_NAME_LONG, qnum_q, 16'd0, 16'd0, id_n);
          n_res = 2'd1;
        end else if (last) begin
          res0  = mk_verdict(V_TRUNCATED, qnum_q, 16'd0, 16'd0, id_n);
          n_res = 2'd1;
        end else if (name_len_q != 9'd0) begin
          res0  = mk_char(DOT_CHAR, qnum_q, id_n);
          n_res = 2'd1;
        end
      end
      PH_LABEL: begin
        res0  = mk_char(b, qnum_q, id_n);
        n_res = 2'd1;
        if (last) begin
          res1  = mk_verdict(V_TRUNCATED, qnum_q, 16'd0, 16'd0, id_n);
          n_res = 2'd2;
        end
      end
      PH_TYPECLASS: begin
        if (tc_pos_q != 2'd3) begin
          if (last) begin
            res0  = mk_verdict(V_TRUNCATED, qnum_q, 16'd0, 16'd0, id_n);
            n_res = 2'd1;
          end
        end else begin
          res0  = mk_qdone(qnum_q, qtype, qclass, id_n);
          n_res = 2'd1;
          if (type_hit) begin
            res1  = mk_verdict(V_FOUND, qnum_q, qtype, qclass, id_n);
            n_res = 2'd2;
          end else if (qnum_inc == qtotal_q) begin
            res1  = mk_verdict(V_NO_MATCH, qnum_inc, 16'd0, 16'd0, id_n);
            n_res = 2'd2;
          end else if (last) begin
            res1  = mk_verdict(V_TRUNCATED, qnum_inc, 16'd0, 16'd0, id_n);
            n_res = 2'd2;
          end
        end
      end
      PH_IGNORE: ;
      default: ;
    endcase
  end

  assign fin = (n_res == 2'd1 && res0.kind == KIND_VERDICT) ||
               (n_res == 2'd2 && res1.kind == KIND_VERDICT);

  // The final byte of a packet always returns the parser to the header phase.
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      if (last) begin
        phase_d = PH_HEADER;
      end else if (fin) begin
        phase_d = PH_IGNORE;
      end else begin
        unique case (phase_q)
          PH_HEADER:    if (hpos_q == HDR_LAST) phase_d = PH_LENGTH;
          PH_LENGTH:    phase_d = (b == 8'd0) ? PH_TYPECLASS : PH_LABEL;
          PH_LABEL:     if (lbl_rem_q == 8'd1) phase_d = PH_LENGTH;
          PH_TYPECLASS: if (tc_pos_q == 2'd3) phase_d = PH_LENGTH;
          PH_IGNORE:    phase_d = PH_IGNORE;
          default:      phase_d = PH_HEADER;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_q <= WANTED_RESET;
    end else if (cfg_we_i) begin
      wanted_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      hpos_q     <= '0;
      held_id_q  <= '0;
      qtotal_q   <= '0;
      other_q    <= 1'b0;
      qnum_q     <= '0;
      lbl_rem_q  <= '0;
      name_len_q <= '0;
      tc_pos_q   <= '0;
      tc_word_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      if (last) begin
        hpos_q     <= '0;
        held_id_q  <= '0;
        qtotal_q   <= '0;
        other_q    <= 1'b0;
        qnum_q     <= '0;
        lbl_rem_q  <= '0;
        name_len_q <= '0;
        tc_pos_q   <= '0;
        tc_word_q  <= '0;
      end else begin
        case (phase_q)
          PH_HEADER: begin
            held_id_q <= id_n;
            if (hpos_q == 4'd4 || hpos_q == 4'd5) begin
              qtotal_q <= {qtotal_q[7:0], b};
            end
            other_q <= other_n;
            if (hpos_q < HDR_LAST) begin
              hpos_q <= hpos_q + 4'd1;
            end else begin
              qnum_q     <= '0;
              name_len_q <= '0;
            end
          end
          PH_LENGTH: begin
            if (b == 8'd0) begin
              tc_pos_q  <= '0;
              tc_word_q <= '0;
            end else begin
              name_len_q <= len_pos;
              lbl_rem_q  <= b;
            end
          end
          PH_LABEL: begin
            name_len_q <= name_len_q + 9'd1;
            lbl_rem_q  <= lbl_rem_q - 8'd1;
          end
          PH_TYPECLASS: begin
            tc_word_q <= tc_word_n;
            if (tc_pos_q != 2'd3) begin
              tc_pos_q <= tc_pos_q + 2'd1;
            end else begin
              tc_pos_q   <= '0;
              qnum_q     <= qnum_inc;
              name_len_q <= '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Result queue.
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  result_t        queue_q [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  cnt_q;
  logic [1:0]     n_push;
  logic           pop;

  assign s_axis_tready = cnt_q <= CW'(QUEUE_DEPTH - 2);
  assign n_push        = accept ? n_res : 2'd0;
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (n_push == 2'd2) begin
      queue_q[wr_ptr_q + PW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PW'(n_push);
      rd_ptr_q <= rd_ptr_q + PW'(pop);
      cnt_q    <= cnt_q + CW'(n_push) - CW'(pop);
    end
  end

  result_t head;
  assign head          = queue_q[rd_ptr_q];
  assign m_axis_tvalid = cnt_q != '0;
  assign m_axis_tdata  = {5'b00000, head.verdict, head.message_id, head.query_class,
                          head.query_type, head.question_index, head.name_char};
  assign m_axis_tlast  = head.final_of_packet;
  assign m_axis_tuser  = head.kind;

endmodule

// ===== rtl/core/dqqp_checker.sv =====
`include "dns_query_question_parser_defines.svh"

module dqqp_checker import dqqp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [1:0]  m_axis_tuser
);

  // Only a verdict closes a packet.
  `DQQP_ASSERT(a_last_is_verdict, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == KIND_VERDICT)))
  // Name characters and finished questions carry a zero verdict field.
  `DQQP_ASSERT(a_verdict_zero, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser != KIND_VERDICT) |-> (m_axis_tdata[74:72] == 3'd0))
  // The result queue is empty right out of reset.
  `DQQP_ASSERT_ALWAYS(a_empty_after_reset, clk_i, !rst_ni |=> !m_axis_tvalid)
  `DQQP_ASSERT(a_valid_holds, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
  `DQQP_ASSERT(a_data_holds, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))

endmodule

bind dns_query_question_parser dqqp_checker u_dqqp_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import dqqp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 120;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [15:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;

  // Shared between the stimulus and the result-side process.
  bit no_idle   = 1'b0;
  bit hold_req  = 1'b0;
  int cycles    = 0;

  dns_query_question_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Tracks the parse of each packet and holds the results it should produce.
  class question_board;
    result_t     pending_results[$];
    int          errors;
    logic [15:0] wanted;
    phase_e      ph;
    logic [3:0]  hdr_pos;
    logic [15:0] msg_id;
    logic [15:0] q_total;
    bit          other_seen;
    logic [15:0] q_num;
    logic [7:0]  label_left;
    logic [8:0]  name_len;
    logic [1:0]  tc_pos;
    logic [31:0] tc_word;

    function new();
      errors = 0;
      wanted = WANTED_RESET;
      restart();
    endfunction

    function void restart();
      ph         = PH_HEADER;
      hdr_pos    = '0;
      msg_id     = '0;
      q_total    = '0;
      other_seen = 1'b0;
      q_num      = '0;
      label_left = '0;
      name_len   = '0;
      tc_pos     = '0;
      tc_word    = '0;
    endfunction

    function void emit(kind_e k, logic [7:0] ch, logic [15:0] qt, logic [15:0] qc,
                       verdict_e v, logic fin);
      result_t r;
      r                 = '0;
      r.kind            = k;
      r.name_char       = ch;
      r.question_index  = q_num;
      r.query_type      = qt;
      r.query_class     = qc;
      r.message_id      = msg_id;
      r.verdict         = v;
      r.final_of_packet = fin;
      pending_results.push_back(r);
    endfunction

    function void conclude(verdict_e v, logic [15:0] qt, logic [15:0] qc, logic eop);
      emit(KIND_VERDICT, 8'h00, qt, qc, v, 1'b1);
      if (eop) restart();
      else ph = PH_IGNORE;
    endfunction

    // Called for every accepted input item.
    function void take_byte(logic [7:0] b, logic eop);
      int pos;
      logic [15:0] qt;
      logic [15:0] qc;
      case (ph)
        PH_HEADER: begin
          if (hdr_pos < 2) msg_id = {msg_id[7:0], b};
          else if (hdr_pos == 4 || hdr_pos == 5) q_total = {q_total[7:0], b};
          else if (hdr_pos >= 6 && b != 8'h00) other_seen = 1'b1;
          if (hdr_pos < HDR_LAST) begin
            hdr_pos = hdr_pos + 4'd1;
            if (eop) conclude(V_SHORT_HDR, '0, '0, 1'b1);
          end else if (other_seen) begin
            conclude(V_NON_QUEST, '0, '0, eop);
          end else if (q_total == 16'd0) begin
            conclude(V_NO_MATCH, '0, '0, eop);
          end else begin
            q_num    = '0;
            name_len = '0;
            ph       = PH_LENGTH;
            if (eop) conclude(V_TRUNCATED, '0, '0, 1'b1);
          end
        end
        PH_LENGTH: begin
          if (b == 8'h00) begin
            tc_pos  = '0;
            tc_word = '0;
            ph      = PH_TYPECLASS;
            if (eop) conclude(V_TRUNCATED, '0, '0, 1'b1);
          end else begin
            pos = int'(name_len) + ((name_len != 0) ? 1 : 0);
            if (pos + int'(b) >= NAME_LIMIT) begin
              conclude(V_NAME_LONG, '0, '0, eop);
            end else if (eop) begin
              conclude(V_TRUNCATED, '0, '0, 1'b1);
            end else begin
              // The dot goes out only once the next label is known to fit.
              if (name_len != 0) emit(KIND_CHAR, DOT_CHAR, '0, '0, V_FOUND, 1'b0);
              name_len   = 9'(pos);
              label_left = b;
              ph         = PH_LABEL;
            end
          end
        end
        PH_LABEL: begin
          emit(KIND_CHAR, b, '0, '0, V_FOUND, 1'b0);
          name_len   = name_len + 9'd1;
          label_left = label_left - 8'd1;
          if (label_left == 8'd0) ph = PH_LENGTH;
          if (eop) conclude(V_TRUNCATED, '0, '0, 1'b1);
        end
        PH_TYPECLASS: begin
          tc_word = {tc_word[23:0], b};
          if (tc_pos < 2'd3) begin
            tc_pos = tc_pos + 2'd1;
            if (eop) conclude(V_TRUNCATED, '0, '0, 1'b1);
          end else begin
            qt     = tc_word[31:16];
            qc     = tc_word[15:0];
            tc_pos = '0;
            emit(KIND_QDONE, 8'h00, qt, qc, V_FOUND, 1'b0);
            if (qt == wanted) begin
              conclude(V_FOUND, qt, qc, eop);
            end else begin
              q_num = q_num + 16'd1;
              if (q_num == q_total) begin
                conclude(V_NO_MATCH, '0, '0, eop);
              end else begin
                name_len = '0;
                ph       = PH_LENGTH;
                if (eop) conclude(V_TRUNCATED, '0, '0, 1'b1);
              end
            end
          end
        end
        default: begin
          if (eop) restart();
        end
      endcase
    endfunction

    function void match_result(logic [1:0] kind, logic [79:0] d, logic fin);
      result_t e;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result kind=%0d data=%h last=%b", kind, d, fin);
        return;
      end
      e = pending_results.pop_front();
      if (kind !== e.kind || d[7:0] !== e.name_char || d[23:8] !== e.question_index ||
          d[39:24] !== e.query_type || d[55:40] !== e.query_class ||
          d[71:56] !== e.message_id || d[74:72] !== e.verdict ||
          fin !== e.final_of_packet) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: result mismatch at cycle %0d", cycles);
          $display("  expected kind=%0d char=%h q=%h type=%h class=%h id=%h verdict=%0d last=%b",
                   e.kind, e.name_char, e.question_index, e.query_type, e.query_class,
                   e.message_id, e.verdict, e.final_of_packet);
          $display("  actual   kind=%0d char=%h q=%h type=%h class=%h id=%h verdict=%0d last=%b",
                   kind, d[7:0], d[23:8], d[39:24], d[55:40], d[71:56], d[74:72], fin);
        end
      end
    endfunction
  endclass

  question_board board = new();

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Both handshakes are sampled at the edge, before any update of this step.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        board.match_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready)
        board.take_byte(s_axis_tdata, s_axis_tlast);
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= rst_ni && (no_idle || $urandom_range(99) >= 7);
      end
    end
  end

  task automatic send_stream(input logic [8:0] s[$]);
    foreach (s[i]) begin
      while (!no_idle && $urandom_range(99) < 7) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= s[i][7:0];
      s_axis_tlast  <= s[i][8];
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until the block has delivered everything, then let it settle.
  task automatic wait_drained();
    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_wanted(input logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    board.wanted = v;
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic void put_header(ref logic [7:0] p[$], input logic [15:0] mid,
                                     input logic [15:0] qd, input int other_at);
    p.push_back(mid[15:8]);
    p.push_back(mid[7:0]);
    p.push_back(8'($urandom));
    p.push_back(8'($urandom));
    p.push_back(qd[15:8]);
    p.push_back(qd[7:0]);
    for (int i = 6; i < HDR_BYTES; i++)
      p.push_back((i == other_at) ? 8'($urandom_range(1, 255)) : 8'h00);
  endfunction

  function automatic void put_question(ref logic [7:0] p[$], input int labels,
                                       input logic [15:0] qt, input logic [15:0] qc);
    int len;
    for (int l = 0; l < labels; l++) begin
      len = ($urandom_range(199) == 0) ? $urandom_range(9, 255) : $urandom_range(1, 8);
      p.push_back(8'(len));
      repeat (len) p.push_back(8'($urandom));
    end
    p.push_back(8'h00);
    p.push_back(qt[15:8]);
    p.push_back(qt[7:0]);
    p.push_back(qc[15:8]);
    p.push_back(qc[7:0]);
  endfunction

  function automatic void commit(ref logic [8:0] s[$], input logic [7:0] p[$]);
    foreach (p[i]) s.push_back({(i == p.size() - 1) ? 1'b1 : 1'b0, p[i]});
  endfunction

  function automatic logic [15:0] pick_type(input logic [15:0] want);
    int r;
    r = $urandom_range(99);
    if (r < 40) return want;
    if (r < 55) return 16'd28;
    if (r < 70) return 16'd1;
    return 16'($urandom);
  endfunction

  // Styles: 0 well formed, 1 cut short, 2 other records, 3 no questions,
  // 4 oversized label, 5 noise.
  function automatic void add_packet(ref logic [8:0] s[$], input logic [15:0] want,
                                     input int style);
    logic [7:0] p[$];
    logic [15:0] qd;
    int nq;
    int cut;
    qd = 16'($urandom_range(1, 4));
    if (style == 3) qd = '0;
    else if ($urandom_range(99) < 5) qd = 16'($urandom);
    put_header(p, 16'($urandom), qd, (style == 2) ? $urandom_range(6, 11) : -1);
    if (style == 4) begin
      p.push_back(8'd1);
      p.push_back(8'($urandom));
      p.push_back(8'($urandom_range(254, 255)));
    end else if (style != 3) begin
      nq = (qd > 4) ? 4 : int'(qd);
      repeat (nq)
        put_question(p, $urandom_range(1, 3), pick_type(want),
                     ($urandom_range(1) == 1) ? 16'd1 : 16'($urandom));
    end
    repeat ($urandom_range(0, 3)) p.push_back(8'($urandom));
    if (style == 1) begin
      cut = $urandom_range(1, p.size());
      while (p.size() > cut) void'(p.pop_back());
    end
    if (style == 5) begin
      p.delete();
      repeat ($urandom_range(1, 20)) p.push_back(8'($urandom));
    end
    commit(s, p);
  endfunction

  logic [15:0] phase_wanted[5] = '{16'h0000, 16'hFFFF, 16'h0000, 16'd1, 16'd28};

  initial begin
    logic [8:0] s[$];
    logic [7:0] p[$];
    int r;
    int style;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed packets, with the wanted type at its reset value.
    p = '{8'h12};
    commit(s, p);
    p.delete();
    put_header(p, 16'hFFFF, 16'd1, -1);
    commit(s, p);
    p.delete();
    put_header(p, 16'h0000, 16'd1, 7);
    p.push_back(8'hFF);
    p.push_back(8'h00);
    commit(s, p);
    p.delete();
    put_header(p, 16'hA5C3, 16'd0, -1);
    commit(s, p);
    p.delete();
    put_header(p, 16'h1234, 16'd2, -1);
    put_question(p, 1, 16'd1, 16'd1);
    put_question(p, 2, WANTED_RESET, 16'hFFFF);
    p.push_back(8'h00);
    p.push_back(8'hFF);
    commit(s, p);
    // A second label that would reach the name limit.
    p.delete();
    put_header(p, 16'h0102, 16'd1, -1);
    p.push_back(8'd1);
    p.push_back(8'h78);
    p.push_back(8'd254);
    p.push_back(8'h41);
    commit(s, p);
    // Packet ends on a label character.
    p.delete();
    put_header(p, 16'h5555, 16'd1, -1);
    p.push_back(8'd3);
    p.push_back(8'h61);
    p.push_back(8'h62);
    commit(s, p);
    // A compression pointer is read as a plain label length.
    p.delete();
    put_header(p, 16'h0001, 16'd1, -1);
    p.push_back(8'hC0);
    p.push_back(8'h0C);
    commit(s, p);
    send_stream(s);

    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      write_wanted((ph == 2) ? 16'($urandom) : phase_wanted[ph]);
      s.delete();
      while (s.size() < PHASE_BYTES) begin
        r = $urandom_range(99);
        if (r < 62) style = 0;
        else if (r < 74) style = 1;
        else if (r < 81) style = 2;
        else if (r < 86) style = 3;
        else if (r < 92) style = 4;
        else style = 5;
        add_packet(s, board.wanted, style);
      end
      if (ph == 1) hold_req = 1'b1;
      if (ph == 3) no_idle = 1'b1;
      send_stream(s);
      no_idle = 1'b0;
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    board.errors += board.pending_results.size();
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
